>>> sv/strong_coupling_eval_macros.svh
// strong_coupling_eval_macros.svh: assertion macros for the coupling evaluator
// expects clk and arst_n in the scope that includes it
`ifndef STRONG_COUPLING_EVAL_MACROS_SVH
`define STRONG_COUPLING_EVAL_MACROS_SVH
`ifndef ASSERT_OFF
// condition that holds at every edge out of reset
`define SCE_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("invariant check failed");
// same-cycle implication
`define SCE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`else
`define SCE_ASSERT(lbl, cond)
`define SCE_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

>>> sv/sce_pkg.sv
// sce_pkg: constants, types and coefficient tables of the coupling evaluator
// used by sce_log2 and strong_coupling_eval; depends on nothing
package sce_pkg;

	localparam int FRAC_W  = 28;
	localparam int SCALE_W = 48;
	localparam int CFG_W   = 32;
	localparam int LQ_W    = 34;
	localparam int KB_W    = 57;

	localparam logic [27:0] LN2_Q28 = 28'd186065280;
	localparam logic [31:0] SAT32   = 32'hFFFF_FFFF;
	localparam logic [31:0] ONE_Q28 = 32'h1000_0000;

	// 12*pi in Q.56, from pi in Q.60 truncated
	localparam logic [63:0] K12PI  = 64'h25B2_F8FE_6643_A460;
	localparam logic [KB_W-1:0] KB_NF3 = KB_W'(K12PI / 64'd27);
	localparam logic [KB_W-1:0] KB_NF4 = KB_W'(K12PI / 64'd25);
	localparam logic [KB_W-1:0] KB_NF5 = KB_W'(K12PI / 64'd23);

	// rounded-up reciprocals of the coefficient denominators
	// (x * rcp) >> 59 is the exact floor of x / d for any x below 2^49
	localparam int RCP_SHIFT = 59;
	localparam logic [63:0] RCP_NF3 = ((64'd1 << RCP_SHIFT) + 64'd80) / 64'd81;
	localparam logic [63:0] RCP_NF4 = ((64'd1 << RCP_SHIFT) + 64'd624) / 64'd625;
	localparam logic [63:0] RCP_NF5 = ((64'd1 << RCP_SHIFT) + 64'd528) / 64'd529;

	typedef enum logic [1:0] {
		REGION_NF3 = 2'd0,
		REGION_NF4 = 2'd1,
		REGION_NF5 = 2'd2
	} region_t;

	typedef enum logic [1:0] {
		MODE_OFF,
		MODE_FIXED,
		MODE_FIRST,
		MODE_SECOND
	} mode_t;

	typedef struct packed {
		region_t region;
		mode_t   mode;
	} ctx_t;

	function automatic logic [KB_W-1:0] kb_of(input region_t r);
		case (r)
			REGION_NF3: kb_of = KB_NF3;
			REGION_NF4: kb_of = KB_NF4;
			default:    kb_of = KB_NF5;
		endcase
	endfunction

	function automatic logic [8:0] cnum_of(input region_t r);
		case (r)
			REGION_NF3: cnum_of = 9'd64;
			REGION_NF4: cnum_of = 9'd462;
			default:    cnum_of = 9'd348;
		endcase
	endfunction

	function automatic logic [52:0] rcp_of(input region_t r);
		case (r)
			REGION_NF3: rcp_of = RCP_NF3[52:0];
			REGION_NF4: rcp_of = RCP_NF4[52:0];
			default:    rcp_of = RCP_NF5[52:0];
		endcase
	endfunction

endpackage

>>> sv/sce_log2.sv
// sce_log2: pipelined log2 in Q.28, msb search then one squaring per stage
// depends on sce_pkg
module sce_log2 #(
	parameter int IW = 48,
	parameter int PW = 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic [IW-1:0]                        x,
	input  logic [PW-1:0]                        in_pl,
	output logic                                 out_valid,
	output logic [$clog2(IW)+sce_pkg::FRAC_W-1:0] y,
	output logic [PW-1:0]                        out_pl
);
	localparam int EW  = $clog2(IW);
	localparam int FW  = sce_pkg::FRAC_W;
	localparam int MW  = 32;
	localparam int NSQ = FW;

	logic [EW-1:0] msb;
	logic [EW-1:0] msb_s1;
	logic [IW-1:0] x_s1;
	logic [PW-1:0] pl_s1;
	logic          vld_s1;
	logic [IW-1:0] shifted;
	logic [MW-1:0] norm;

	logic [MW-1:0]   mant_s [0:NSQ];
	logic [FW-1:0]   frac_s [0:NSQ];
	logic [EW-1:0]   exp_s  [0:NSQ];
	logic [PW-1:0]   pl_s   [0:NSQ];
	logic [NSQ:0]    vld_s;
	logic [2*MW-1:0] sq       [1:NSQ];
	logic [MW-1:0]   nxt_mant [1:NSQ];
	logic [FW-1:0]   nxt_frac [1:NSQ];

	// msb index
	always_comb begin
		msb = '0;
		for (int i = 0; i < IW; i++) begin
			if (x[i]) begin
				msb = EW'(i);
			end
		end
	end

	// mantissa to Q1.31
	assign shifted = x_s1 << (EW'(IW - 1) - msb_s1);
	assign norm    = shifted[IW-1 -: MW];

	// one fraction bit per stage
	always_comb begin
		for (int k = 1; k <= NSQ; k++) begin
			sq[k] = {{MW{1'b0}}, mant_s[k-1]} * {{MW{1'b0}}, mant_s[k-1]};
			if (sq[k][2*MW-1]) begin
				nxt_mant[k] = sq[k][2*MW-1:MW];
				nxt_frac[k] = frac_s[k-1] | (FW'(1) << (NSQ - k));
			end else begin
				nxt_mant[k] = sq[k][2*MW-2:MW-1];
				nxt_frac[k] = frac_s[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s  <= '0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s  <= {vld_s[NSQ-1:0], vld_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			msb_s1    <= msb;
			x_s1      <= x;
			pl_s1     <= in_pl;
			mant_s[0] <= norm;
			frac_s[0] <= '0;
			exp_s[0]  <= msb_s1;
			pl_s[0]   <= pl_s1;
			for (int k = 1; k <= NSQ; k++) begin
				mant_s[k] <= nxt_mant[k];
				frac_s[k] <= nxt_frac[k];
				exp_s[k]  <= exp_s[k-1];
				pl_s[k]   <= pl_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[NSQ];
	assign y         = {exp_s[NSQ], frac_s[NSQ]};
	assign out_pl    = pl_s[NSQ];

endmodule

>>> sv/sce_div.sv
// sce_div: pipelined restoring divider, one quotient bit per stage
// caller keeps dividend >> QW below the divisor; no package needed
module sce_div #(
	parameter int NW = 57,
	parameter int DW = 34,
	parameter int QW = 32,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	input  logic [PW-1:0] in_pl,
	output logic          out_valid,
	output logic [QW-1:0] quot,
	output logic [PW-1:0] out_pl
);
	logic [DW-1:0] rem_s [0:QW];
	logic [QW-1:0] qd_s  [0:QW];
	logic [DW-1:0] dv_s  [0:QW];
	logic [PW-1:0] pl_s  [0:QW];
	logic [QW:0]   vld_s;

	logic [DW:0]   trial   [1:QW];
	logic [DW:0]   sub     [1:QW];
	logic          take    [1:QW];
	logic [DW-1:0] nxt_rem [1:QW];

	always_comb begin
		for (int k = 1; k <= QW; k++) begin
			trial[k]   = {rem_s[k-1], qd_s[k-1][QW-1]};
			sub[k]     = trial[k] - {1'b0, dv_s[k-1]};
			take[k]    = trial[k] >= {1'b0, dv_s[k-1]};
			nxt_rem[k] = take[k] ? sub[k][DW-1:0] : trial[k][DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[QW-1:0], in_valid};
		end
	end

	// dividend low bits shift out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DW'(dividend[NW-1:QW]);
			qd_s[0]  <= dividend[QW-1:0];
			dv_s[0]  <= divisor;
			pl_s[0]  <= in_pl;
			for (int k = 1; k <= QW; k++) begin
				rem_s[k] <= nxt_rem[k];
				qd_s[k]  <= {qd_s[k-1][QW-2:0], take[k]};
				dv_s[k]  <= dv_s[k-1];
				pl_s[k]  <= pl_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign quot      = qd_s[QW];
	assign out_pl    = pl_s[QW];

endmodule

>>> sv/strong_coupling_eval.sv
// strong_coupling_eval: two-loop running strong coupling, fully pipelined
// depends on sce_pkg, sce_log2, sce_div and strong_coupling_eval_macros.svh
//
//  channel   | signals                                    | direction
//  ----------+--------------------------------------------+----------
//  scale     | scale_valid, scale_stall, scale_sq         | in
//  result    | result_valid, result_stall, coupling_full, | out
//            | coupling_first, second_factor,             |
//            | flavour_region, out_of_range               |
//  config    | cfg_wr_en, cfg_index, cfg_data             | in
//
// one transaction per cycle while no result is held back
// the pipeline holds two 30-stage log2 units in series (the lambda log runs
// beside the scale log), dividers of 33 and 42 stages and a 3-stage reciprocal multiply
// a stalled result freezes the whole pipeline; bubbles travel as invalid slots
// reset clears valid bits and loads the register defaults; no clearing pass
`include "strong_coupling_eval_macros.svh"

module strong_coupling_eval (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         scale_valid,
	output logic                         scale_stall,
	input  logic [sce_pkg::SCALE_W-1:0]  scale_sq,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [31:0]                  coupling_full,
	output logic [31:0]                  coupling_first,
	output logic [31:0]                  second_factor,
	output logic [1:0]                   flavour_region,
	output logic                         out_of_range,
	input  logic                         cfg_wr_en,
	input  logic [2:0]                   cfg_index,
	input  logic [sce_pkg::CFG_W-1:0]    cfg_data
);
	localparam int FW  = sce_pkg::FRAC_W;
	localparam int LQW = sce_pkg::LQ_W;
	localparam int SW  = sce_pkg::SCALE_W;
	localparam int CW  = $bits(sce_pkg::ctx_t);

	// register map
	localparam logic [2:0] CFG_ENABLED    = 3'd0;
	localparam logic [2:0] CFG_LOOP_ORDER = 3'd1;
	localparam logic [2:0] CFG_COUP_REF   = 3'd2;
	localparam logic [2:0] CFG_CHARM      = 3'd3;
	localparam logic [2:0] CFG_BOTTOM     = 3'd4;
	localparam logic [2:0] CFG_LAMBDA3    = 3'd5;
	localparam logic [2:0] CFG_LAMBDA4    = 3'd6;
	localparam logic [2:0] CFG_LAMBDA5    = 3'd7;

	localparam logic [40:0] RATIO_CAP = 41'h100_0000_0000;

	typedef struct packed {
		sce_pkg::ctx_t  ctx;
		logic [LQW-1:0] lq;
		logic           ovf;
	} d1_pl_t;

	typedef struct packed {
		sce_pkg::ctx_t  ctx;
		logic [LQW-1:0] lq;
		logic [31:0]    first;
		logic           bad;
	} lc_pl_t;

	typedef struct packed {
		sce_pkg::ctx_t ctx;
		logic [31:0]   first;
		logic          bad;
		logic          neg;
		logic          ovf;
	} d2_pl_t;

	typedef struct packed {
		sce_pkg::ctx_t ctx;
		logic [31:0]   first;
		logic          bad;
		logic          neg;
	} d3_pl_t;

	// configuration registers
	logic        enabled_q;
	logic [1:0]  loop_order_q;
	logic [31:0] coupling_ref_q;
	logic [31:0] charm_q;
	logic [31:0] bottom_q;
	logic [31:0] lambda3_q;
	logic [31:0] lambda4_q;
	logic [31:0] lambda5_q;

	// global advance
	logic en;

	// entry
	sce_pkg::ctx_t ctx_in;
	logic [31:0]   lam_in;
	logic [SW-1:0] scale_s1;
	logic [31:0]   lam_s1;
	sce_pkg::ctx_t ctx_s1;
	logic          zs_s1;
	logic          vld_s1;

	// scale and lambda logs
	logic           va, vb;
	logic [33:0]    la;
	logic [32:0]    lb;
	logic           zs_a;
	logic [CW-1:0]  ctx_b;

	logic [34:0]    a_ext;
	logic [34:0]    b_ext;
	logic [LQW-1:0] diff_s2;
	sce_pkg::ctx_t  ctx_s2;
	logic           vld_s2;

	logic [61:0]    lq_prod;
	logic [LQW-1:0] lq_s3;
	sce_pkg::ctx_t  ctx_s3;
	logic           vld_s3;

	// first-order divide
	d1_pl_t                 d1_in, d1_out;
	logic [sce_pkg::KB_W-1:0] kb;
	logic                   v_d1;
	logic [31:0]            q1;

	logic [31:0]    first_s5;
	logic [LQW-1:0] lq_s5;
	logic           bad_s5;
	sce_pkg::ctx_t  ctx_s5;
	logic           vld_s5;

	// log of L
	lc_pl_t         lc_in, lc_out;
	logic           v_lc;
	logic [33:0]    g;

	logic [33:0]    mag_s6;
	logic           neg_s6;
	lc_pl_t         lc_s6;
	logic           vld_s6;

	logic [61:0]    ln_prod;
	logic [33:0]    lnmag_s7;
	logic           neg_s7;
	lc_pl_t         lc_s7;
	logic           vld_s7;

	// ratio divide
	d2_pl_t         d2_in, d2_out;
	logic           v_d2;
	logic [40:0]    q2;

	logic [40:0]    ratio_s9;
	d3_pl_t         p_s9;
	logic           vld_s9;

	logic [48:0]    prod_s10;
	d3_pl_t         p_s10;
	logic           vld_s10;

	// constant-coefficient divide by reciprocal multiply
	logic [52:0]    rcp;
	logic [24:0]    xh;
	logic [23:0]    xl;
	logic [51:0]    pp_hh_s11;
	logic [50:0]    pp_hl_s11;
	logic [50:0]    pp_lh_s11;
	logic [49:0]    pp_ll_s11;
	d3_pl_t         p_s11;
	logic           vld_s11;

	logic [51:0]    pp_hh_s12;
	logic [53:0]    mid_s12;
	logic [49:0]    pp_ll_s12;
	d3_pl_t         p_s12;
	logic           vld_s12;

	logic [101:0]   rcp_sum;
	logic [43:0]    term_s13;
	d3_pl_t         p_s13;
	logic           vld_s13;

	logic [44:0]    fac_sum;
	logic [31:0]    factor_s14;
	d3_pl_t         p_s14;
	logic           vld_s14;

	logic [63:0]    full_prod;
	logic [31:0]    full_s15;
	logic [31:0]    factor_s15;
	d3_pl_t         p_s15;
	logic           vld_s15;

	// output register
	logic [31:0]    full_nxt, first_nxt, factor_nxt;
	logic           oor_nxt;
	logic [31:0]    full_s16, first_s16, factor_s16;
	logic [1:0]     region_s16;
	logic           oor_s16;
	logic           vld_s16;

	// ---------------- configuration port ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q      <= 1'b0;
			loop_order_q   <= 2'd1;
			coupling_ref_q <= 32'd31675383;
			charm_q        <= 32'd147456;
			bottom_q       <= 32'd1509949;
			lambda3_q      <= 32'd1677722;
			lambda4_q      <= 32'd1342177;
			lambda5_q      <= 32'd838861;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_ENABLED:    enabled_q      <= cfg_data[0];
				CFG_LOOP_ORDER: loop_order_q   <= cfg_data[1:0];
				CFG_COUP_REF:   coupling_ref_q <= cfg_data;
				CFG_CHARM:      charm_q        <= cfg_data;
				CFG_BOTTOM:     bottom_q       <= cfg_data;
				CFG_LAMBDA3:    lambda3_q      <= cfg_data;
				CFG_LAMBDA4:    lambda4_q      <= cfg_data;
				CFG_LAMBDA5:    lambda5_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// the pipeline moves unless a finished result is held back
	assign en          = !vld_s16 || !result_stall;
	assign scale_stall = !en;

	// ---------------- entry: region, mode, lambda ----------------
	always_comb begin
		if (scale_sq > SW'(bottom_q)) begin
			ctx_in.region = sce_pkg::REGION_NF5;
		end else if (scale_sq > SW'(charm_q)) begin
			ctx_in.region = sce_pkg::REGION_NF4;
		end else begin
			ctx_in.region = sce_pkg::REGION_NF3;
		end
		if (!enabled_q) begin
			ctx_in.mode = sce_pkg::MODE_OFF;
		end else if (loop_order_q == 2'd0) begin
			ctx_in.mode = sce_pkg::MODE_FIXED;
		end else if (loop_order_q == 2'd1) begin
			ctx_in.mode = sce_pkg::MODE_FIRST;
		end else begin
			// order three runs as second order
			ctx_in.mode = sce_pkg::MODE_SECOND;
		end
		case (ctx_in.region)
			sce_pkg::REGION_NF5: lam_in = lambda5_q;
			sce_pkg::REGION_NF4: lam_in = lambda4_q;
			default:             lam_in = lambda3_q;
		endcase
		// a zero lambda register counts as one
		if (lam_in == 32'd0) begin
			lam_in = 32'd1;
		end
	end

	// ---------------- ln(scale / lambda) ----------------
	sce_log2 #(.IW(SW), .PW(1)) u_log_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s1),
		.x         (scale_s1),
		.in_pl     (zs_s1),
		.out_valid (va),
		.y         (la),
		.out_pl    (zs_a)
	);

	sce_log2 #(.IW(32), .PW(CW)) u_log_lambda (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s1),
		.x         (lam_s1),
		.in_pl     (ctx_s1),
		.out_valid (vb),
		.y         (lb),
		.out_pl    (ctx_b)
	);

	// scale is UQ.16 and lambda UQ.24: add 8 to the scale log
	assign a_ext   = 35'(la) + (35'(8) << FW);
	assign b_ext   = 35'(lb);
	assign lq_prod = 62'(diff_s2) * 62'(sce_pkg::LN2_Q28);

	// ---------------- first order: K_b / L ----------------
	assign kb         = sce_pkg::kb_of(ctx_s3.region);
	assign d1_in.ctx  = ctx_s3;
	assign d1_in.lq   = lq_s3;
	// quotient would not fit 32 bits (also catches L of zero)
	assign d1_in.ovf  = LQW'(kb[sce_pkg::KB_W-1:32]) >= lq_s3;

	sce_div #(.NW(sce_pkg::KB_W), .DW(LQW), .QW(32), .PW($bits(d1_pl_t))) u_div_first (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.dividend  (kb),
		.divisor   (lq_s3),
		.in_pl     (d1_in),
		.out_valid (v_d1),
		.quot      (q1),
		.out_pl    (d1_out)
	);

	// ---------------- ln(L) ----------------
	assign lc_in.ctx   = ctx_s5;
	assign lc_in.lq    = lq_s5;
	assign lc_in.first = first_s5;
	assign lc_in.bad   = bad_s5;

	sce_log2 #(.IW(LQW), .PW($bits(lc_pl_t))) u_log_l (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s5),
		.x         (lq_s5),
		.in_pl     (lc_in),
		.out_valid (v_lc),
		.y         (g),
		.out_pl    (lc_out)
	);

	assign ln_prod = 62'(mag_s6) * 62'(sce_pkg::LN2_Q28);

	// ---------------- |ln L| / L ----------------
	assign d2_in.ctx   = lc_s7.ctx;
	assign d2_in.first = lc_s7.first;
	assign d2_in.bad   = lc_s7.bad;
	assign d2_in.neg   = neg_s7;
	// quotient of 2^41 or more is past the cap
	assign d2_in.ovf   = LQW'(lnmag_s7[33:13]) >= lc_s7.lq;

	sce_div #(.NW(62), .DW(LQW), .QW(41), .PW($bits(d2_pl_t))) u_div_ratio (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s7),
		.dividend  ({lnmag_s7, {FW{1'b0}}}),
		.divisor   (lc_s7.lq),
		.in_pl     (d2_in),
		.out_valid (v_d2),
		.quot      (q2),
		.out_pl    (d2_out)
	);

	// ---------------- ratio * c: divide by the denominator ----------------
	// product split into four partial products of at most 25 x 27 bits
	assign rcp     = sce_pkg::rcp_of(p_s10.ctx.region);
	assign xh      = prod_s10[48:24];
	assign xl      = prod_s10[23:0];
	assign rcp_sum = (102'(pp_hh_s12) << 50) + (102'(mid_s12) << 24) + 102'(pp_ll_s12);

	assign fac_sum   = 45'(sce_pkg::ONE_Q28) + 45'(term_s13);
	assign full_prod = 64'(p_s14.first) * 64'(factor_s14);

	// ---------------- result selection by mode ----------------
	always_comb begin
		full_nxt   = '0;
		first_nxt  = '0;
		factor_nxt = sce_pkg::ONE_Q28;
		oor_nxt    = 1'b0;
		unique case (p_s15.ctx.mode)
			sce_pkg::MODE_OFF: begin
				full_nxt  = '0;
				first_nxt = '0;
			end
			sce_pkg::MODE_FIXED: begin
				full_nxt  = coupling_ref_q;
				first_nxt = coupling_ref_q;
			end
			sce_pkg::MODE_FIRST: begin
				full_nxt  = p_s15.bad ? sce_pkg::SAT32 : p_s15.first;
				first_nxt = full_nxt;
				oor_nxt   = p_s15.bad;
			end
			sce_pkg::MODE_SECOND: begin
				full_nxt   = p_s15.bad ? sce_pkg::SAT32 : full_s15;
				first_nxt  = p_s15.bad ? sce_pkg::SAT32 : p_s15.first;
				factor_nxt = p_s15.bad ? sce_pkg::SAT32 : factor_s15;
				oor_nxt    = p_s15.bad;
			end
			default: ;
		endcase
	end

	// ---------------- valid chain ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
			vld_s15 <= 1'b0;
			vld_s16 <= 1'b0;
		end else if (en) begin
			vld_s1  <= scale_valid;
			vld_s2  <= va;
			vld_s3  <= vld_s2;
			vld_s5  <= v_d1;
			vld_s6  <= v_lc;
			vld_s7  <= vld_s6;
			vld_s9  <= v_d2;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
			vld_s15 <= vld_s14;
			vld_s16 <= vld_s15;
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: entry
			scale_s1 <= scale_sq;
			lam_s1   <= lam_in;
			ctx_s1   <= ctx_in;
			zs_s1    <= scale_sq == '0;
			// s2: log difference, zero when scale at or below lambda
			diff_s2  <= (!zs_a && a_ext > b_ext) ? LQW'(a_ext - b_ext) : '0;
			ctx_s2   <= ctx_b;
			// s3: L in Q.28
			lq_s3    <= lq_prod[61:FW];
			ctx_s3   <= ctx_s2;
			// s5: first-order coupling
			first_s5 <= d1_out.ovf ? sce_pkg::SAT32 : q1;
			lq_s5    <= d1_out.lq;
			bad_s5   <= d1_out.lq == '0;
			ctx_s5   <= d1_out.ctx;
			// s6: |log2 L - 28|, sign
			neg_s6   <= g < (34'(28) << FW);
			mag_s6   <= (g < (34'(28) << FW)) ? (34'(28) << FW) - g : g - (34'(28) << FW);
			lc_s6    <= lc_out;
			// s7: |ln L|
			lnmag_s7 <= ln_prod[61:FW];
			neg_s7   <= neg_s6;
			lc_s7    <= lc_s6;
			// s9: capped ratio
			ratio_s9 <= (d2_out.ovf || q2 > RATIO_CAP) ? RATIO_CAP : q2;
			p_s9.ctx   <= d2_out.ctx;
			p_s9.first <= d2_out.first;
			p_s9.bad   <= d2_out.bad;
			p_s9.neg   <= d2_out.neg;
			// s10: ratio times numerator, below 2^49
			prod_s10 <= 49'(50'(ratio_s9) * 50'(sce_pkg::cnum_of(p_s9.ctx.region)));
			p_s10    <= p_s9;
			// s11: partial products with the reciprocal
			pp_hh_s11 <= 52'(xh) * 52'(rcp[52:26]);
			pp_hl_s11 <= 51'(xh) * 51'(rcp[25:0]);
			pp_lh_s11 <= 51'(xl) * 51'(rcp[52:26]);
			pp_ll_s11 <= 50'(xl) * 50'(rcp[25:0]);
			p_s11     <= p_s10;
			// s12: middle partial products merged
			pp_hh_s12 <= pp_hh_s11;
			mid_s12   <= 54'(pp_hl_s11) + (54'(pp_lh_s11) << 2);
			pp_ll_s12 <= pp_ll_s11;
			p_s12     <= p_s11;
			// s13: quotient by the coefficient denominator
			term_s13  <= 44'(rcp_sum[101:sce_pkg::RCP_SHIFT]);
			p_s13     <= p_s12;
			// s14: correction factor
			if (p_s13.neg) begin
				factor_s14 <= (fac_sum > 45'(sce_pkg::SAT32)) ? sce_pkg::SAT32 : fac_sum[31:0];
			end else begin
				factor_s14 <= (term_s13 >= 44'(sce_pkg::ONE_Q28)) ? '0 :
					sce_pkg::ONE_Q28 - term_s13[31:0];
			end
			p_s14    <= p_s13;
			// s15: second-order coupling
			full_s15   <= (full_prod[63:60] != 4'd0) ? sce_pkg::SAT32 : full_prod[59:FW];
			factor_s15 <= factor_s14;
			p_s15      <= p_s14;
			// s16: output
			full_s16   <= full_nxt;
			first_s16  <= first_nxt;
			factor_s16 <= factor_nxt;
			region_s16 <= p_s15.ctx.region;
			oor_s16    <= oor_nxt;
		end
	end

	assign result_valid   = vld_s16;
	assign coupling_full  = full_s16;
	assign coupling_first = first_s16;
	assign second_factor  = factor_s16;
	assign flavour_region = region_s16;
	assign out_of_range   = oor_s16;

	// ---------------- checks ----------------
	// the two log units share one enable and must stay aligned
	`SCE_ASSERT(a_log_lockstep, va == vb)
	// an out-of-range transaction always reports saturated couplings
	`SCE_ASSERT_IMP(a_oor_saturates, result_valid && out_of_range, coupling_first == sce_pkg::SAT32 && coupling_full == sce_pkg::SAT32)
	// a held result must back-pressure the input side
	`SCE_ASSERT_IMP(a_stall_propagates, result_valid && result_stall, scale_stall)

endmodule

>>> dv/strong_coupling_eval_test.sv
// strong_coupling_eval_test: self-checking testbench of the two-loop coupling evaluator
// holds a scoreboard class with its own fixed-point predictor and plain driver tasks
// depends on sce_pkg and the strong_coupling_eval rtl only
module strong_coupling_eval_test;
	timeunit 1ns;
	timeprecision 1ps;

	// register map, index equals position in the register list
	typedef enum logic [2:0] {
		REG_ENABLED, REG_LOOP_ORDER, REG_COUPLING_REF, REG_CHARM_SQ,
		REG_BOTTOM_SQ, REG_LAMBDA3_SQ, REG_LAMBDA4_SQ, REG_LAMBDA5_SQ
	} reg_index_t;

	localparam logic [1:0] ORDER_FIXED  = 2'd0;
	localparam logic [1:0] ORDER_FIRST  = 2'd1;
	localparam logic [1:0] ORDER_SECOND = 2'd2;
	localparam logic [1:0] ORDER_ALIAS  = 2'd3;
	localparam logic [47:0] SCALE_MAX   = 48'hFFFF_FFFF_FFFF;
	localparam int PIPE_DEPTH = 149;

	typedef struct packed {
		logic [31:0]      full;
		logic [31:0]      first;
		logic [31:0]      factor;
		sce_pkg::region_t region;
		logic             bad;
	} coupling_t;

	// scoreboard: predicts the coupling for each accepted scale and checks results in order
	class coupling_board;
		logic        enabled;
		logic [1:0]  order;
		logic [31:0] cref, charm_sq, bottom_sq;
		logic [31:0] lam_sq [3];
		coupling_t   expected_q[$];
		int          errors, n_scales, n_results, n_bad, n_region[3];

		function new();
			enabled = 1'b0;
			order = ORDER_FIRST;
			cref = 32'd31675383;
			charm_sq = 32'd147456;
			bottom_sq = 32'd1509949;
			lam_sq[0] = 32'd1677722;
			lam_sq[1] = 32'd1342177;
			lam_sq[2] = 32'd838861;
		endfunction

		function void set_reg(reg_index_t idx, logic [31:0] val);
			case (idx)
				REG_ENABLED:      enabled = val[0];
				REG_LOOP_ORDER:   order = val[1:0];
				REG_COUPLING_REF: cref = val;
				REG_CHARM_SQ:     charm_sq = val;
				REG_BOTTOM_SQ:    bottom_sq = val;
				REG_LAMBDA3_SQ:   lam_sq[0] = val;
				REG_LAMBDA4_SQ:   lam_sq[1] = val;
				default:          lam_sq[2] = val;
			endcase
		endfunction

		// log2 in Q.28 by repeated squaring of a Q1.31 mantissa
		function logic [63:0] log2_q28(logic [63:0] x);
			int e;
			logic [63:0] m, f;
			e = 63;
			f = '0;
			while (e > 0 && !x[e]) e--;
			m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
			for (int i = 27; i >= 0; i--) begin
				m = (m * m) >> 31;
				if ((m >> 32) != 0) begin
					m = m >> 1;
					f[i] = 1'b1;
				end
			end
			return (64'(e) << 28) + f;
		endfunction

		function coupling_t predict(logic [47:0] s);
			coupling_t r;
			logic [63:0] lam, lq, a, b, kb, g, mag, lnmag, ratio, term, first, prod;
			logic [63:0] beta, cnum, cden;
			bit neg;
			if (s > 48'(bottom_sq)) r.region = sce_pkg::REGION_NF5;
			else if (s > 48'(charm_sq)) r.region = sce_pkg::REGION_NF4;
			else r.region = sce_pkg::REGION_NF3;
			lam = 64'(lam_sq[r.region]);
			if (lam == 0) lam = 1;
			case (r.region)
				sce_pkg::REGION_NF3: begin beta = 27; cnum = 64;  cden = 81;  end
				sce_pkg::REGION_NF4: begin beta = 25; cnum = 462; cden = 625; end
				default:             begin beta = 23; cnum = 348; cden = 529; end
			endcase
			r.factor = sce_pkg::ONE_Q28;
			r.bad = 1'b0;
			if (!enabled) begin
				r.full = '0;
				r.first = '0;
			end else if (order == ORDER_FIXED) begin
				r.full = cref;
				r.first = cref;
			end else begin
				lq = 0;
				if (s != 0) begin
					a = log2_q28(64'(s)) + (64'd8 << 28);
					b = log2_q28(lam);
					if (a > b) lq = ((a - b) * 64'(sce_pkg::LN2_Q28)) >> 28;
				end
				if (lq == 0) begin
					// scale at or below lambda: the couplings saturate, and in second order the factor too
					r.bad = 1'b1;
					r.first = sce_pkg::SAT32;
					r.full = sce_pkg::SAT32;
					if (order >= ORDER_SECOND) r.factor = sce_pkg::SAT32;
				end else begin
					kb = ((64'h3243_F6A8_885A_308D >> 4) * 12) / beta;
					first = kb / lq;
					r.first = (first > 64'(sce_pkg::SAT32)) ? sce_pkg::SAT32 : first[31:0];
					r.full = r.first;
					if (order >= ORDER_SECOND) begin
						g = log2_q28(lq);
						neg = g < (64'd28 << 28);
						mag = neg ? (64'd28 << 28) - g : g - (64'd28 << 28);
						lnmag = (mag * 64'(sce_pkg::LN2_Q28)) >> 28;
						ratio = (lnmag << 28) / lq;
						if (ratio > (64'd1 << 40)) ratio = 64'd1 << 40;
						term = ratio * cnum / cden;
						if (neg) begin
							term = term + 64'(sce_pkg::ONE_Q28);
							r.factor = (term > 64'(sce_pkg::SAT32)) ? sce_pkg::SAT32 :
								term[31:0];
						end else begin
							r.factor = (term >= 64'(sce_pkg::ONE_Q28)) ? '0 :
								32'(64'(sce_pkg::ONE_Q28) - term);
						end
						prod = (64'(r.first) * 64'(r.factor)) >> 28;
						r.full = (prod > 64'(sce_pkg::SAT32)) ? sce_pkg::SAT32 : prod[31:0];
					end
				end
			end
			return r;
		endfunction

		function void note_scale(logic [47:0] s);
			coupling_t r;
			r = predict(s);
			expected_q.push_back(r);
			n_scales++;
			n_region[r.region]++;
			if (r.bad) n_bad++;
		endfunction

		function void check_result(coupling_t got);
			coupling_t e;
			n_results++;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result transaction, actual %h", $time, got);
				return;
			end
			e = expected_q.pop_front();
			if (got.full !== e.full) begin
				errors++;
				$display("%0t: coupling_full expected %h actual %h", $time, e.full, got.full);
			end
			if (got.first !== e.first) begin
				errors++;
				$display("%0t: coupling_first expected %h actual %h", $time, e.first, got.first);
			end
			if (got.factor !== e.factor) begin
				errors++;
				$display("%0t: second_factor expected %h actual %h", $time, e.factor,
					got.factor);
			end
			if (got.region !== e.region) begin
				errors++;
				$display("%0t: flavour_region expected %0d actual %0d", $time, e.region,
					got.region);
			end
			if (got.bad !== e.bad) begin
				errors++;
				$display("%0t: out_of_range expected %b actual %b", $time, e.bad, got.bad);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        scale_valid;
	logic        scale_stall;
	logic [47:0] scale_sq;
	logic        result_valid;
	logic        result_stall;
	logic [31:0] coupling_full, coupling_first, second_factor;
	logic [1:0]  flavour_region;
	logic        out_of_range;
	logic        cfg_wr_en;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	coupling_board board;
	bit tx_idle_on, rx_idle_on, hold_req;
	int n_holds_seen;

	strong_coupling_eval dut (
		.clk(clk), .arst_n(arst_n),
		.scale_valid(scale_valid), .scale_stall(scale_stall), .scale_sq(scale_sq),
		.result_valid(result_valid), .result_stall(result_stall),
		.coupling_full(coupling_full), .coupling_first(coupling_first),
		.second_factor(second_factor), .flavour_region(flavour_region),
		.out_of_range(out_of_range),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// monitors: inputs and results are taken at the edge that accepts them
	always @(posedge clk) begin
		if (arst_n && scale_valid && !scale_stall) board.note_scale(scale_sq);
		if (arst_n && scale_valid && scale_stall && result_stall) n_holds_seen++;
		if (arst_n && result_valid && !result_stall)
			board.check_result({coupling_full, coupling_first, second_factor,
				sce_pkg::region_t'(flavour_region), out_of_range});
	end

	// receiver: random stall bursts, a long hold-off on request, none in the last part
	initial begin
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				// long hold-off so the pipeline fills and pushes back on the sender
				result_stall <= 1'b1;
				repeat (2 * PIPE_DEPTH + 50) @(posedge clk);
				hold_req = 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				result_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// send one scale transaction, with an optional idle burst in front
	task automatic send_scale(input logic [47:0] s);
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			scale_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		scale_valid <= 1'b1;
		scale_sq <= s;
		@(posedge clk);
		while (scale_stall) @(posedge clk);
	endtask

	// wait until every expected result has come back, with the sender quiet
	task automatic drain();
		scale_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write; only called while the pipeline is empty
	task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.set_reg(idx, val);
		@(posedge clk);
	endtask

	// one-bit and two-bit registers get junk in the upper data bits
	task automatic set_mode(input logic en, input logic [1:0] ord);
		write_reg(REG_ENABLED, {$urandom} & 32'hFFFF_FFFE | 32'(en));
		write_reg(REG_LOOP_ORDER, {$urandom} & 32'hFFFF_FFFC | 32'(ord));
	endtask

	task automatic set_bounds(input logic [31:0] c, b, l3, l4, l5);
		write_reg(REG_CHARM_SQ, c);
		write_reg(REG_BOTTOM_SQ, b);
		write_reg(REG_LAMBDA3_SQ, l3);
		write_reg(REG_LAMBDA4_SQ, l4);
		write_reg(REG_LAMBDA5_SQ, l5);
	endtask

	// scale mix: full-width noise, log-uniform, around thresholds and lambdas, tiny
	function automatic logic [47:0] pick_scale();
		logic [63:0] w;
		logic [47:0] s;
		int k;
		w = {$urandom, $urandom};
		k = $urandom_range(0, 2);
		case ($urandom_range(0, 6))
			0: s = w[47:0];
			1, 2: s = w[47:0] >> $urandom_range(0, 47);
			3: s = 48'(board.charm_sq) + 48'($urandom_range(0, 8)) - 48'd4;
			4: s = 48'(board.bottom_sq) + 48'($urandom_range(0, 8)) - 48'd4;
			5: s = 48'(board.lam_sq[k] >> 8) + 48'($urandom_range(0, 4000)) - 48'd40;
			default: s = 48'($urandom_range(0, 15));
		endcase
		return s;
	endfunction

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) send_scale(pick_scale());
		drain();
	endtask

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		logic [47:0] special [$];
		board = new();
		arst_n = 1'b0;
		scale_valid = 1'b0;
		scale_sq = '0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_ENABLED;
		cfg_data = '0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		hold_req = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: disabled, couplings read zero, region still reported
		run_random(100);

		// directed: extremes, thresholds, lambda edge, ln(L) sign change
		set_mode(1'b1, ORDER_SECOND);
		special = '{48'd0, 48'd1, SCALE_MAX, 48'h8000_0000_0000, 48'h1_0000,
			48'd147455, 48'd147456, 48'd147457, 48'd1509948, 48'd1509949, 48'd1509950,
			48'd6553, 48'd6554, 48'd6555, 48'd6600, 48'd14000, 48'd17814, 48'd20000,
			48'd5243, 48'd5244, 48'd3276, 48'd3277, 48'h0000_FFFF_FFFF, 48'h5555_5555_5555};
		foreach (special[i]) send_scale(special[i]);
		drain();
		run_random(280);

		// first order running at reset thresholds
		set_mode(1'b1, ORDER_FIRST);
		run_random(230);

		// fixed coupling at both reference extremes
		set_mode(1'b1, ORDER_FIXED);
		write_reg(REG_COUPLING_REF, 32'd0);
		run_random(60);
		write_reg(REG_COUPLING_REF, 32'hFFFF_FFFF);
		run_random(60);

		// order three aliases second order; threshold and lambda extremes
		set_mode(1'b1, ORDER_ALIAS);
		set_bounds(32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd1);
		run_random(200);
		set_bounds(32'hFFFF_FFFF, 32'd0, 32'd1, 32'd0, 32'hFFFF_FFFF);
		run_random(200);

		// random settings with a long receiver hold-off to fill the pipeline
		set_mode(1'b1, ORDER_SECOND);
		write_reg(REG_COUPLING_REF, $urandom);
		set_bounds($urandom >> 8, $urandom >> 4, $urandom >> 6, $urandom >> 6, $urandom >> 6);
		hold_req = 1'b1;
		run_random(320);

		// last part: realistic settings, no idling on either side
		set_bounds(32'd147456, 32'd1509949, 32'd1677722, 32'd1342177, 32'd838861);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		run_random(280);
		repeat (PIPE_DEPTH + 20) @(posedge clk);

		$display("covered %0d scales (regions 3/4/5 flavours: %0d/%0d/%0d), %0d below lambda",
			board.n_scales, board.n_region[0], board.n_region[1], board.n_region[2],
			board.n_bad);
		$display("orders zero to three, disabled mode, threshold and lambda extremes, %0d %s",
			n_holds_seen, "back-pressured cycles");
		if (board.errors == 0 && board.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

>>> sim.f
+incdir+sv
sv/sce_pkg.sv
sv/sce_log2.sv
sv/sce_div.sv
sv/strong_coupling_eval.sv
dv/strong_coupling_eval_test.sv
